/* design/tfss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfss_pkg: shared definitions of the timed frame slot sequencer
// Operation codes, register indexes, reset values and the divider status.
// ----------------------------------------------------------------------------
package tfss_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int SLOT_BITS_DEF = 10;

    localparam int DURATION_RESET = 1280000;
    localparam int CAPACITY_RESET = 1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [2:0] REG_DURATION = 3'd0;
    localparam logic [2:0] REG_LOOP     = 3'd1;
    localparam logic [2:0] REG_START    = 3'd2;
    localparam logic [2:0] REG_END      = 3'd3;
    localparam logic [2:0] REG_CAPACITY = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

/* design/tfss_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfss_div: bit-serial restoring divider
// Takes one dividend bit per cycle, MSB first, and leaves quotient and
// remainder in place; done pulses for one cycle when they are ready.
// ----------------------------------------------------------------------------
module tfss_div
    import tfss_pkg::*;
#(
    parameter int DIVIDEND_BITS = TIME_BITS_DEF + SLOT_BITS_DEF,
    parameter int DIVISOR_BITS  = TIME_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic      [DIVIDEND_BITS-1:0] quotient,
    output logic      [DIVISOR_BITS-1:0]  remainder,
    output div_status_t                   status
);

    localparam int CW = $clog2(DIVIDEND_BITS);

    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so either
            // result fits the divisor width.
            rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DIVIDEND_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

/* design/timed_frame_slot_sequencer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_frame_slot_sequencer_core: frame index sequencer driven by time
// Stop, reserved and ignored words go straight to the emit state; a tick
// passes through the bit-serial multiplier and the shared bit-serial
// divider, which runs up to three times per word.
// Throughput: one word at a time; the next word is taken once the result
// sits in the output register. Reset clears the active flag, elapsed time,
// the controller and the result valid flag; configuration registers
// return to their reset values.
// ----------------------------------------------------------------------------
module timed_frame_slot_sequencer_core
    import tfss_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int SLOT_BITS = SLOT_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    // input channel
    input  wire logic                 op_valid,
    output logic                      op_ready,
    input  wire logic [1:0]           operation,
    input  wire logic [TIME_BITS-1:0] delta_time,
    // result channel
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic                      frame_changed,
    output logic                      pass_done,
    output logic      [SLOT_BITS-1:0] frame_index,
    output logic                      running
);

    localparam int W   = TIME_BITS + SLOT_BITS;
    localparam int MCW = $clog2(SLOT_BITS);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_MUL_OLD = 8'b0000_0010,
        S_DIV_OLD = 8'b0000_0100,
        S_CHECK   = 8'b0000_1000,
        S_DIV_MOD = 8'b0001_0000,
        S_MUL_NEW = 8'b0010_0000,
        S_DIV_NEW = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } state_t;

    // Configuration registers
    logic [TIME_BITS-1:0] duration_reg;
    logic                 loop_reg;
    logic [SLOT_BITS-1:0] start_slot_reg;
    logic [SLOT_BITS-1:0] end_slot_reg;
    logic [SLOT_BITS-1:0] cap_reg;
    logic                 cfg_write;
    logic [2:0]           cfg_index;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg   <= TIME_BITS'(DURATION_RESET);
            loop_reg       <= 1'b1;
            start_slot_reg <= '0;
            end_slot_reg   <= '0;
            cap_reg        <= SLOT_BITS'(CAPACITY_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DURATION: duration_reg   <= pwdata[TIME_BITS-1:0];
                REG_LOOP:     loop_reg       <= pwdata[0];
                REG_START:    start_slot_reg <= pwdata[SLOT_BITS-1:0];
                REG_END:      end_slot_reg   <= pwdata[SLOT_BITS-1:0];
                REG_CAPACITY: cap_reg        <= pwdata[SLOT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_DURATION: prdata = 32'(duration_reg);
            REG_LOOP:     prdata = 32'(loop_reg);
            REG_START:    prdata = 32'(start_slot_reg);
            REG_END:      prdata = 32'(end_slot_reg);
            REG_CAPACITY: prdata = 32'(cap_reg);
            default:      prdata = '0;
        endcase
    end

    // Clamped slot range and frame count
    logic [SLOT_BITS-1:0] s_cl;
    logic [SLOT_BITS-1:0] e_cl;
    logic [SLOT_BITS-1:0] count;
    logic                 cfg_bad;

    always_comb
    begin
        s_cl = (start_slot_reg >= cap_reg) ? cap_reg : start_slot_reg;
        e_cl = (end_slot_reg >= cap_reg) ? cap_reg : end_slot_reg;
        if (s_cl == '0 && e_cl == '0)
        begin
            count = cap_reg;
        end
        else
        begin
            count = (e_cl >= s_cl) ? (e_cl - s_cl) : (s_cl - e_cl);
        end
        cfg_bad = (duration_reg == '0) || (cap_reg == '0);
    end

    // Controller and datapath registers
    state_t               state_reg, state_next;
    logic                 active_reg, active_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS:0]   t_reg, t_next;
    logic                 have_old_reg, have_old_next;
    logic [W-1:0]         old_rel_reg, old_rel_next;
    logic                 launch_reg, launch_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         mcand_reg, mcand_next;
    logic [SLOT_BITS-1:0] mplier_reg, mplier_next;
    logic [MCW-1:0]       mcnt_reg, mcnt_next;
    logic                 pdone_reg, pdone_next;
    logic                 pchanged_reg, pchanged_next;
    logic [SLOT_BITS-1:0] pframe_reg, pframe_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 frame_changed_reg, frame_changed_next;
    logic                 pass_done_reg, pass_done_next;
    logic [SLOT_BITS-1:0] frame_index_reg, frame_index_next;
    logic                 running_reg, running_next;

    // Shared divider
    logic [W-1:0]         div_dividend;
    logic [W-1:0]         div_quo;
    logic [TIME_BITS-1:0] div_rem;
    div_status_t          div_stat;

    assign div_dividend = (state_reg == S_DIV_MOD) ? W'(t_reg) : acc_reg;

    tfss_div #(
        .DIVIDEND_BITS (W),
        .DIVISOR_BITS  (TIME_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (launch_reg),
        .dividend  (div_dividend),
        .divisor   (duration_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_stat)
    );

    logic [SLOT_BITS-1:0] new_rel;

    assign new_rel = div_quo[SLOT_BITS-1:0];

    always_comb
    begin
        state_next         = state_reg;
        active_next        = active_reg;
        elapsed_next       = elapsed_reg;
        t_next             = t_reg;
        have_old_next      = have_old_reg;
        old_rel_next       = old_rel_reg;
        launch_next        = 1'b0;
        acc_next           = acc_reg;
        mcand_next         = mcand_reg;
        mplier_next        = mplier_reg;
        mcnt_next          = mcnt_reg;
        pdone_next         = pdone_reg;
        pchanged_next      = pchanged_reg;
        pframe_next        = pframe_reg;
        res_valid_next     = res_valid_reg && !res_ready;
        frame_changed_next = frame_changed_reg;
        pass_done_next     = pass_done_reg;
        frame_index_next   = frame_index_reg;
        running_next       = running_reg;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (op_valid)
                begin
                    have_old_next = (operation == OP_TICK);
                    t_next        = {1'b0, elapsed_reg} + {1'b0, delta_time};
                    pdone_next    = 1'b0;
                    pchanged_next = 1'b0;
                    pframe_next   = '0;
                    state_next    = S_EMIT;
                    case (operation) inside
                        OP_STOP:
                        begin
                            active_next = 1'b0;
                        end
                        OP_TICK, OP_START:
                        begin
                            if (operation == OP_START || active_reg)
                            begin
                                if (cfg_bad)
                                begin
                                    active_next = 1'b0;
                                end
                                else if (operation == OP_START)
                                begin
                                    t_next     = '0;
                                    state_next = S_CHECK;
                                end
                                else
                                begin
                                    acc_next    = '0;
                                    mcand_next  = W'(elapsed_reg);
                                    mplier_next = count;
                                    mcnt_next   = '0;
                                    state_next  = S_MUL_OLD;
                                end
                            end
                        end
                        default:
                        begin
                            // Reserved code: the active flag and elapsed time stay as they are.
                        end
                    endcase
                end
            end

            S_MUL_OLD, S_MUL_NEW:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                mcnt_next   = mcnt_reg + MCW'(1);
                if (mcnt_reg == MCW'(SLOT_BITS - 1))
                begin
                    launch_next = 1'b1;
                    state_next  = (state_reg == S_MUL_OLD) ? S_DIV_OLD : S_DIV_NEW;
                end
            end

            S_DIV_OLD:
            begin
                if (div_stat.done)
                begin
                    old_rel_next = div_quo;
                    state_next   = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (t_reg >= {1'b0, duration_reg})
                begin
                    pdone_next = 1'b1;
                    if (loop_reg)
                    begin
                        launch_next = 1'b1;
                        state_next  = S_DIV_MOD;
                    end
                    else
                    begin
                        active_next = 1'b0;
                        state_next  = S_EMIT;
                    end
                end
                else
                begin
                    active_next  = 1'b1;
                    elapsed_next = t_reg[TIME_BITS-1:0];
                    acc_next     = '0;
                    mcand_next   = W'(t_reg[TIME_BITS-1:0]);
                    mplier_next  = count;
                    mcnt_next    = '0;
                    state_next   = S_MUL_NEW;
                end
            end

            S_DIV_MOD:
            begin
                if (div_stat.done)
                begin
                    active_next  = 1'b1;
                    elapsed_next = div_rem;
                    acc_next     = '0;
                    mcand_next   = W'(div_rem);
                    mplier_next  = count;
                    mcnt_next    = '0;
                    state_next   = S_MUL_NEW;
                end
            end

            S_DIV_NEW:
            begin
                if (div_stat.done)
                begin
                    // A start has no previous frame, so it always reports.
                    if (!have_old_reg || div_quo != old_rel_reg)
                    begin
                        pchanged_next = 1'b1;
                        pframe_next   = (s_cl <= e_cl) ? (s_cl + new_rel)
                                                       : (s_cl - SLOT_BITS'(1) - new_rel);
                    end
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next     = 1'b1;
                    frame_changed_next = pchanged_reg;
                    pass_done_next     = pdone_reg;
                    frame_index_next   = pframe_reg;
                    running_next       = active_next;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            elapsed_reg   <= '0;
            launch_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            elapsed_reg   <= elapsed_next;
            launch_reg    <= launch_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg             <= t_next;
        have_old_reg      <= have_old_next;
        old_rel_reg       <= old_rel_next;
        acc_reg           <= acc_next;
        mcand_reg         <= mcand_next;
        mplier_reg        <= mplier_next;
        mcnt_reg          <= mcnt_next;
        pdone_reg         <= pdone_next;
        pchanged_reg      <= pchanged_next;
        pframe_reg        <= pframe_next;
        frame_changed_reg <= frame_changed_next;
        pass_done_reg     <= pass_done_next;
        frame_index_reg   <= frame_index_next;
        running_reg       <= running_next;
    end

    assign op_ready      = (state_reg == S_IDLE);
    assign res_valid     = res_valid_reg;
    assign frame_changed = frame_changed_reg;
    assign pass_done     = pass_done_reg;
    assign frame_index   = frame_index_reg;
    assign running       = running_reg;

    // A reported frame always comes with the sequencer left running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && frame_changed_reg) |-> running_reg)
        else $error("frame reported while sequencer stopped");

    // The divider only works inside one of the division states.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV_OLD || state_reg == S_DIV_MOD ||
                           state_reg == S_DIV_NEW))
        else $error("divider busy outside a division state");

    // A finished word waits while the output register is still occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && res_valid_reg && !res_ready) |=> (state_reg == S_EMIT))
        else $error("result overwritten before it was taken");

    // The new relative frame is below the count, so it fits the slot width.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_NEW && div_stat.done) |-> (div_quo[W-1:SLOT_BITS] == '0))
        else $error("relative frame out of range");

endmodule
`default_nettype wire
